@@ rtl/keyed_group_sum_aggregator_core_macros.svh @@
// Assertion helpers for the group-sum aggregator checker.
// Both expect aclk and aresetn in scope.
`ifndef KEYED_GROUP_SUM_AGGREGATOR_CORE_MACROS_SVH
`define KEYED_GROUP_SUM_AGGREGATOR_CORE_MACROS_SVH

// Implication checked in the same cycle
`define KGSA_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("kgsa: same-cycle check failed");

// Implication checked in the next cycle
`define KGSA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("kgsa: next-cycle check failed");

`endif

@@ rtl/kgsa_pkg.sv @@
package kgsa_pkg;

    // Default sizing
    localparam int DEF_MAX_GROUPS = 64;
    localparam int DEF_SUM_BITS   = 32;

    // Field widths
    localparam int AIRPORT_W = 24;
    localparam int MONTH_W   = 4;
    localparam int PERIOD_W  = 12;
    localparam int FLIGHT_W  = 16;
    localparam int VAL_W     = 20;
    localparam int KEY_W     = AIRPORT_W + PERIOD_W;
    localparam int NUM_SUMS  = 8;
    localparam int OUT_SUM_W = 32;

    // Input tdata layout (lowest bit first)
    localparam int IN_AIRPORT_LSB = 0;
    localparam int IN_MONTH_LSB   = IN_AIRPORT_LSB + AIRPORT_W;
    localparam int IN_YEAR_LSB    = IN_MONTH_LSB + MONTH_W;
    localparam int IN_DELAYED_LSB = IN_YEAR_LSB + PERIOD_W;
    localparam int IN_TOTAL_LSB   = IN_DELAYED_LSB + FLIGHT_W;
    localparam int IN_MIN_LSB     = IN_TOTAL_LSB + FLIGHT_W;
    localparam int IN_DATA_W      = IN_MIN_LSB + 6 * VAL_W;

    // Output tdata layout (lowest bit first), padded to whole bytes
    localparam int OUT_SUM_LSB = KEY_W;
    localparam int OUT_USED_W  = OUT_SUM_LSB + NUM_SUMS * OUT_SUM_W;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    // Operation codes carried on s_tuser
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_BY_MONTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BY_YEAR  = 1'd1;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [VAL_W-1:0] val_t;

endpackage

@@ rtl/keyed_group_sum_aggregator_core.sv @@
// Group-by accumulator for airport delay records.
// Input channel s_*: one item per record or command. s_tuser is the operation
// (add or flush), s_tdata carries airport, month, year and eight counts.
// An add builds a key from airport and month (by_month) or year (by_year),
// looks it up in a table kept in block RAM and adds the counts into saturating
// sums, or takes the next free entry. A full table drops the record and sets
// a sticky overflow flag. With no mode set an add changes nothing.
// A flush emits each stored group on m_* in insertion order, tlast on the
// final one, then empties the table and clears the overflow flag.
// Sequencing: an add holds the input while the key RAM is scanned one entry a
// cycle through its single read port, and on a hit while the sums are updated.
// A flush reads each group from RAM, then loads it into the output register; an
// empty flush and a no-mode add leave the block idle.
// Adds are taken while a result still waits in the output register; a flush
// waits for that register. A stalled receiver holds m_* and stalls the flush.
// Reset (aresetn low, synchronous) empties the table, clears the overflow flag
// and both mode registers; no clearing pass is needed.
module keyed_group_sum_aggregator_core #(
    parameter int MAX_GROUPS = kgsa_pkg::DEF_MAX_GROUPS,
    parameter int SUM_BITS   = kgsa_pkg::DEF_SUM_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [kgsa_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [kgsa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // airport_code, month, year, delayed_flights, total_flights, carrier_minutes,
    // late_aircraft_minutes, airspace_minutes, security_minutes, weather_minutes,
    // all_minutes
    input  logic [kgsa_pkg::IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic                            s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // group_airport, group_period, sum_delayed, sum_total, sum_carrier,
    // sum_late_aircraft, sum_airspace, sum_security, sum_weather, sum_all, pad
    output logic [kgsa_pkg::OUT_DATA_W-1:0] m_tdata,
    // overflowed
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import kgsa_pkg::*;

    localparam int IDX_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CNT_W  = $clog2(MAX_GROUPS + 1);
    localparam int ADD_W  = ((SUM_BITS > VAL_W) ? SUM_BITS : VAL_W) + 1;
    localparam int ROW_W  = NUM_SUMS * SUM_BITS;
    localparam int PAD_W  = OUT_DATA_W - OUT_USED_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_FRD  = 3'd3;
    localparam logic [2:0] ST_FOUT = 3'd4;

    // table storage
    key_t             key_mem [MAX_GROUPS];
    logic [ROW_W-1:0] sum_mem [MAX_GROUPS];
    key_t             key_rd_reg;
    logic [ROW_W-1:0] sum_rd_reg;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             ovf_reg, ovf_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             by_month_reg, by_year_reg;
    logic             m_tvalid_reg, m_tvalid_next;

    // payload state
    key_t             key_reg, key_next;
    val_t             vals_reg [NUM_SUMS];
    val_t             vals_next [NUM_SUMS];
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic             m_tlast_reg, m_tlast_next;
    logic             m_tuser_reg, m_tuser_next;

    // memory port controls
    logic             key_re, sum_re, key_we, sum_we;
    logic [IDX_W-1:0] key_raddr, sum_raddr, wr_addr;
    logic [ROW_W-1:0] sum_wdata;

    logic             hit;
    logic             out_free;
    logic [PERIOD_W-1:0] in_period;
    logic [NUM_SUMS*OUT_SUM_W-1:0] out_sums;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    assign hit      = rd_valid_reg && (key_rd_reg == key_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_period = by_month_reg
                     ? PERIOD_W'(s_tdata[IN_MONTH_LSB +: MONTH_W])
                     : s_tdata[IN_YEAR_LSB +: PERIOD_W];

    // saturating adders, one per sum; base is zero for a new entry
    for (genvar j = 0; j < NUM_SUMS; j++) begin : g_sum
        logic [SUM_BITS-1:0] base;
        logic [ADD_W-1:0]    total;
        assign base  = (state_reg == ST_UPD) ? sum_rd_reg[j*SUM_BITS +: SUM_BITS] : '0;
        assign total = ADD_W'(base) + ADD_W'(vals_reg[j]);
        assign sum_wdata[j*SUM_BITS +: SUM_BITS] =
            (|total[ADD_W-1:SUM_BITS]) ? {SUM_BITS{1'b1}} : total[SUM_BITS-1:0];
        assign out_sums[j*OUT_SUM_W +: OUT_SUM_W] =
            OUT_SUM_W'(sum_rd_reg[j*SUM_BITS +: SUM_BITS]);
    end

    // next-state and memory control
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        ovf_next      = ovf_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        slot_next     = slot_reg;
        key_next      = key_reg;
        vals_next     = vals_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        key_re        = 1'b0;
        sum_re        = 1'b0;
        key_we        = 1'b0;
        sum_we        = 1'b0;
        key_raddr     = issue_reg[IDX_W-1:0];
        sum_raddr     = issue_reg[IDX_W-1:0];
        wr_addr       = count_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                key_next     = {s_tdata[IN_AIRPORT_LSB +: AIRPORT_W], in_period};
                vals_next[0] = VAL_W'(s_tdata[IN_DELAYED_LSB +: FLIGHT_W]);
                vals_next[1] = VAL_W'(s_tdata[IN_TOTAL_LSB +: FLIGHT_W]);
                for (int k = 0; k < 6; k++) begin
                    vals_next[2+k] = s_tdata[IN_MIN_LSB + k*VAL_W +: VAL_W];
                end
                issue_next = '0;
                if (s_tvalid) begin
                    if (s_tuser == OP_FLUSH) begin
                        if (count_reg != '0) begin
                            state_next = ST_FRD;
                        end
                    end else if (by_month_reg || by_year_reg) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    // found: fetch the stored sums of that entry
                    sum_re     = 1'b1;
                    sum_raddr  = rd_idx_reg;
                    slot_next  = rd_idx_reg;
                    state_next = ST_UPD;
                end else if (issue_reg != count_reg) begin
                    // read the next stored key, compare next cycle
                    key_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + CNT_W'(1);
                end else begin
                    // every entry missed: insert or drop
                    if (count_reg < CNT_W'(MAX_GROUPS)) begin
                        key_we     = 1'b1;
                        sum_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_UPD: begin
                sum_we     = 1'b1;
                wr_addr    = slot_reg;
                state_next = ST_IDLE;
            end
            ST_FRD: begin
                key_re     = 1'b1;
                sum_re     = 1'b1;
                state_next = ST_FOUT;
            end
            ST_FOUT: begin
                if (out_free) begin
                    // airport in the lowest bits, then the period
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, out_sums,
                                     key_rd_reg[PERIOD_W-1:0],
                                     key_rd_reg[KEY_W-1:PERIOD_W]};
                    m_tuser_next  = ovf_reg;
                    m_tlast_next  = (issue_reg + CNT_W'(1) == count_reg);
                    issue_next    = issue_reg + CNT_W'(1);
                    if (issue_reg + CNT_W'(1) == count_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_FRD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // table memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_addr] <= key_reg;
        end
        if (key_re) begin
            key_rd_reg <= key_mem[key_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[wr_addr] <= sum_wdata;
        end
        if (sum_re) begin
            sum_rd_reg <= sum_mem[sum_raddr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            ovf_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            by_month_reg <= 1'b0;
            by_year_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            ovf_reg      <= ovf_next;
            rd_valid_reg <= rd_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_BY_MONTH: by_month_reg <= cfg_wdata[0];
                    REG_BY_YEAR:  by_year_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        vals_reg    <= vals_next;
        rd_idx_reg  <= rd_idx_next;
        slot_reg    <= slot_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

@@ rtl/kgsa_checker.sv @@
`include "keyed_group_sum_aggregator_core_macros.svh"

module kgsa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [kgsa_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tlast
);
    import kgsa_pkg::*;

    // a stalled result holds its data
    `KGSA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // an add never produces a result of its own
    `KGSA_ASSERT_NEXT(a_add_silent, s_tvalid && s_tready && s_tuser == OP_ADD && !m_tvalid,
                      !m_tvalid)

    // after the last group is taken the flush is over
    `KGSA_ASSERT_NEXT(a_last_ends, m_tvalid && m_tready && m_tlast, !m_tvalid)

    // no new item is taken while a flush still has groups to send
    `KGSA_ASSERT_NOW(a_flush_busy, m_tvalid && !m_tlast, !s_tready)

endmodule

bind keyed_group_sum_aggregator_core kgsa_checker u_kgsa_checker (.*);

@@ dv/tb.sv @@
module tb;
    import kgsa_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int DRAIN_CYCLES = 80;    // longest add: full table scan plus update
    localparam int HOLD_CYCLES  = 400;   // receiver back-pressure stretch
    localparam int STALL_LIMIT  = 5000;  // cycles without any handshake
    localparam int RAND_ITEMS   = 115;

    // input record, airport in the lowest bits
    typedef struct packed {
        logic [VAL_W-1:0]    all_min, weather_min, security_min, airspace_min;
        logic [VAL_W-1:0]    late_min, carrier_min;
        logic [FLIGHT_W-1:0] total, delayed;
        logic [PERIOD_W-1:0] year;
        logic [MONTH_W-1:0]  month;
        logic [AIRPORT_W-1:0] airport;
    } rec_t;

    // one emitted group
    typedef struct packed {
        logic                                last;
        logic                                ovf;
        logic [NUM_SUMS-1:0][OUT_SUM_W-1:0] sums;
        logic [PERIOD_W-1:0]                 period;
        logic [AIRPORT_W-1:0]                airport;
    } group_res_t;

    // directed step; the t_* columns hold the single group a flush must emit
    typedef struct {
        bit                   mode_m;
        bit                   mode_y;
        logic                 op;
        logic [AIRPORT_W-1:0] airport;
        logic [MONTH_W-1:0]   month;
        logic [PERIOD_W-1:0]  year;
        logic [FLIGHT_W-1:0]  delayed;
        logic [FLIGHT_W-1:0]  total;
        logic [VAL_W-1:0]     minutes;
        bit                   typed;
        logic [AIRPORT_W-1:0] t_airport;
        logic [PERIOD_W-1:0]  t_period;
        logic [31:0]          t_flights;
        logic [31:0]          t_minutes;
    } step_t;

    localparam logic [23:0] AP_ATL = 24'h41544C;
    localparam logic [23:0] AP_ORD = 24'h4F5244;
    localparam logic [23:0] AP_SFO = 24'h53464F;
    localparam logic [23:0] AP_DFW = 24'h444657;
    localparam logic [23:0] AP_JFK = 24'h4A464B;
    localparam logic [23:0] AP_DEN = 24'h44454E;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = OP_ADD;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    keyed_group_sum_aggregator_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // shadow group table
    logic [KEY_W-1:0]                   grp_key  [DEF_MAX_GROUPS];
    logic [NUM_SUMS-1:0][OUT_SUM_W-1:0] grp_sums [DEF_MAX_GROUPS];
    int                                 grp_count = 0;
    bit                                 ovf_flag  = 1'b0;
    bit                                 cfg_month = 1'b0;
    bit                                 cfg_year  = 1'b0;

    group_res_t due_groups [$];
    int         errors       = 0;
    int         stall_cycles = 0;
    bit         quiet        = 1'b0;
    int         hold_reqs    = 0;
    int         hold_seen    = 0;
    int         hold_left    = 0;

    string sum_names [NUM_SUMS] = '{"sum_delayed", "sum_total", "sum_carrier",
        "sum_late_aircraft", "sum_airspace", "sum_security", "sum_weather", "sum_all"};
    logic [23:0] ap_pool [6] = '{AP_ATL, AP_ORD, AP_SFO, AP_DFW, AP_JFK, AP_DEN};

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // group-by update of the shadow table; a flush queues every group in order
    function automatic void aggregate_item(logic op, rec_t r, bit emit);
        logic [KEY_W-1:0]                   key;
        logic [PERIOD_W-1:0]                period;
        logic [NUM_SUMS-1:0][OUT_SUM_W-1:0] add;
        logic [OUT_SUM_W:0]                 s;
        group_res_t                         g;
        int                                 hit;
        if (op == OP_FLUSH) begin
            for (int i = 0; i < grp_count; i++) begin
                g.airport = grp_key[i][KEY_W-1:PERIOD_W];
                g.period  = grp_key[i][PERIOD_W-1:0];
                g.sums    = grp_sums[i];
                g.ovf     = ovf_flag;
                g.last    = (i == grp_count - 1);
                if (emit) due_groups.insert(due_groups.size(), g);
            end
            grp_count = 0;
            ovf_flag  = 1'b0;
            return;
        end
        if (cfg_month) period = PERIOD_W'(r.month);
        else if (cfg_year) period = r.year;
        else return;
        key    = {r.airport, period};
        add[0] = OUT_SUM_W'(r.delayed);
        add[1] = OUT_SUM_W'(r.total);
        add[2] = OUT_SUM_W'(r.carrier_min);
        add[3] = OUT_SUM_W'(r.late_min);
        add[4] = OUT_SUM_W'(r.airspace_min);
        add[5] = OUT_SUM_W'(r.security_min);
        add[6] = OUT_SUM_W'(r.weather_min);
        add[7] = OUT_SUM_W'(r.all_min);
        hit = -1;
        for (int i = 0; i < grp_count; i++) begin
            if (grp_key[i] == key) begin
                hit = i;
                break;
            end
        end
        if (hit >= 0) begin
            // saturating accumulate
            for (int j = 0; j < NUM_SUMS; j++) begin
                s = {1'b0, grp_sums[hit][j]} + {1'b0, add[j]};
                grp_sums[hit][j] = s[OUT_SUM_W] ? '1 : s[OUT_SUM_W-1:0];
            end
        end else if (grp_count < DEF_MAX_GROUPS) begin
            grp_key[grp_count]  = key;
            grp_sums[grp_count] = add;
            grp_count++;
        end else begin
            ovf_flag = 1'b1;
        end
    endfunction

    function automatic rec_t random_record();
        rec_t r;
        r.airport      = ($urandom_range(99) < 75) ? ap_pool[$urandom_range(5)]
                                                   : AIRPORT_W'($urandom);
        r.month        = ($urandom_range(99) < 85) ? MONTH_W'($urandom_range(1, 12))
                                                   : MONTH_W'($urandom_range(0, 15));
        r.year         = ($urandom_range(99) < 80) ? PERIOD_W'(2000 + $urandom_range(3))
                                                   : PERIOD_W'($urandom_range(0, 4095));
        r.delayed      = FLIGHT_W'($urandom_range(0, 16'hFFFF));
        r.total        = FLIGHT_W'($urandom_range(0, 16'hFFFF));
        r.carrier_min  = VAL_W'($urandom_range(0, 20'hFFFFF));
        r.late_min     = VAL_W'($urandom_range(0, 20'hFFFFF));
        r.airspace_min = VAL_W'($urandom_range(0, 20'hFFFFF));
        r.security_min = VAL_W'($urandom_range(0, 20'hFFFFF));
        r.weather_min  = VAL_W'($urandom_range(0, 20'hFFFFF));
        r.all_min      = VAL_W'($urandom_range(0, 20'hFFFFF));
        return r;
    endfunction

    // offer one item, with a random gap first, and update the shadow on accept
    task automatic send_item(input logic op, input rec_t r, input bit emit);
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < 9) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = r;
        do @(posedge aclk); while (!s_tready);
        aggregate_item(op, r, emit);
    endtask

    task automatic go_quiet();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // mode registers change only once the block has drained
    task automatic set_modes(input bit m, input bit y);
        go_quiet();
        while (due_groups.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = REG_BY_MONTH;
        cfg_wdata = CFG_DATA_W'(m);
        @(negedge aclk);
        cfg_addr  = REG_BY_YEAR;
        cfg_wdata = CFG_DATA_W'(y);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        cfg_month = m;
        cfg_year  = y;
    endtask

    // receiver: random stalls, or a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            m_tready  = 1'b0;
        end else begin
            m_tready = quiet || ($urandom_range(99) >= 9);
        end
    end

    // result check and watchdog
    always @(posedge aclk) begin : chk
        group_res_t want;
        logic [OUT_SUM_W-1:0] got;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (due_groups.size() == 0) begin
                $error("group result with none expected: %h", m_tdata);
                errors++;
            end else begin
                want = due_groups.pop_front();
                if (m_tdata[AIRPORT_W-1:0] !== want.airport) begin
                    $error("group_airport: expected %h, got %h",
                           want.airport, m_tdata[AIRPORT_W-1:0]);
                    errors++;
                end
                if (m_tdata[KEY_W-1:AIRPORT_W] !== want.period) begin
                    $error("group_period: expected %0d, got %0d",
                           want.period, m_tdata[KEY_W-1:AIRPORT_W]);
                    errors++;
                end
                for (int j = 0; j < NUM_SUMS; j++) begin
                    got = m_tdata[OUT_SUM_LSB + j * OUT_SUM_W +: OUT_SUM_W];
                    if (got !== want.sums[j]) begin
                        $error("%s: expected %h, got %h", sum_names[j], want.sums[j], got);
                        errors++;
                    end
                end
                if (m_tuser !== want.ovf) begin
                    $error("overflowed: expected %b, got %b", want.ovf, m_tuser);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        step_t       steps [19];
        rec_t        r;
        group_res_t  g;
        logic [23:0] first_ap;
        int          n_rand;
        int          sel;
        bit          m;
        bit          y;

        // mode, op, airport, month, year, delayed, total, minutes,
        // then the typed flush result: airport, period, flight sums, minute sums
        steps = '{
            // no mode: add ignored, flush of an empty table
            '{0, 0, OP_ADD,   AP_ATL,     4'd1,  12'd2008, 16'd5, 16'd10, 20'd100,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            '{0, 0, OP_FLUSH, 24'hFFFFFF, 4'd15, 12'hFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            // month mode: all-ones record, month out of range
            '{1, 0, OP_ADD,   24'hFFFFFF, 4'd15, 12'hFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            '{1, 0, OP_FLUSH, 24'h0, 4'd0, 12'd0, 16'd0, 16'd0, 20'd0,
              1, 24'hFFFFFF, 12'd15, 32'hFFFF, 32'hFFFFF},
            // all-zero record
            '{1, 0, OP_ADD,   24'h0, 4'd0, 12'd0, 16'd0, 16'd0, 20'd0,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            '{1, 0, OP_FLUSH, 24'h0, 4'd0, 12'd0, 16'd0, 16'd0, 20'd0,
              1, 24'h0, 12'd0, 32'h0, 32'h0},
            // hits and misses by month
            '{1, 0, OP_ADD,   AP_ATL, 4'd1,  12'd2008, 16'd12, 16'd40, 20'd300,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            '{1, 0, OP_ADD,   AP_ATL, 4'd1,  12'd2009, 16'd3,  16'd20, 20'd77,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            '{1, 0, OP_ADD,   AP_ORD, 4'd12, 12'd2008, 16'd7,  16'd55, 20'd1234,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            '{1, 0, OP_ADD,   AP_ATL, 4'd12, 12'd2010, 16'd1,  16'd9,  20'd50,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            // switch to year mode without a flush: year 12 joins ATL month 12
            '{0, 1, OP_ADD,   AP_ATL, 4'd3,  12'd12,   16'd2,  16'd4,  20'd8,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            '{0, 1, OP_ADD,   AP_ORD, 4'd5,  12'd2008, 16'd4,  16'd6,  20'd90,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            '{0, 1, OP_ADD,   AP_DFW, 4'd5,  12'hFFF,  16'd9,  16'd11, 20'd4321,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            '{0, 1, OP_FLUSH, 24'h0, 4'd0, 12'd0, 16'd0, 16'd0, 20'd0,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            // both set: month wins
            '{1, 1, OP_ADD,   AP_SFO, 4'd5,  12'd2010, 16'd8,  16'd30, 20'd600,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            '{1, 1, OP_ADD,   AP_SFO, 4'd5,  12'd2011, 16'd6,  16'd25, 20'd500,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            '{1, 1, OP_ADD,   AP_DFW, 4'd6,  12'd2010, 16'd1,  16'd2,  20'd3,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            '{1, 1, OP_FLUSH, 24'h0, 4'd0, 12'd0, 16'd0, 16'd0, 20'd0,
              0, 24'h0, 12'd0, 32'h0, 32'h0},
            // flush right after a clear is empty
            '{1, 1, OP_FLUSH, 24'h0, 4'd0, 12'd0, 16'd0, 16'd0, 20'd0,
              0, 24'h0, 12'd0, 32'h0, 32'h0}
        };

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // directed steps
        foreach (steps[i]) begin
            if (steps[i].mode_m != cfg_month || steps[i].mode_y != cfg_year)
                set_modes(steps[i].mode_m, steps[i].mode_y);
            r = '0;
            r.airport      = steps[i].airport;
            r.month        = steps[i].month;
            r.year         = steps[i].year;
            r.delayed      = steps[i].delayed;
            r.total        = steps[i].total;
            r.carrier_min  = steps[i].minutes;
            r.late_min     = steps[i].minutes;
            r.airspace_min = steps[i].minutes;
            r.security_min = steps[i].minutes;
            r.weather_min  = steps[i].minutes;
            r.all_min      = steps[i].minutes;
            send_item(steps[i].op, r, !steps[i].typed);
            if (steps[i].typed) begin
                g.airport = steps[i].t_airport;
                g.period  = steps[i].t_period;
                g.sums[0] = steps[i].t_flights;
                g.sums[1] = steps[i].t_flights;
                for (int j = 2; j < NUM_SUMS; j++) g.sums[j] = steps[i].t_minutes;
                g.ovf  = 1'b0;
                g.last = 1'b1;
                due_groups.insert(due_groups.size(), g);
            end
        end

        // full table, no idling: 64 distinct years, then dropped new keys and one late hit
        set_modes(1'b0, 1'b1);
        quiet = 1'b1;
        first_ap = '0;
        for (int i = 0; i < DEF_MAX_GROUPS + 3; i++) begin
            r = random_record();
            r.year = (i < DEF_MAX_GROUPS) ? PERIOD_W'(i) : PERIOD_W'(100 + i);
            if (i == 0) first_ap = r.airport;
            send_item(OP_ADD, r, 1'b1);
        end
        r = random_record();
        r.airport = first_ap;
        r.year    = '0;
        send_item(OP_ADD, r, 1'b1);
        quiet = 1'b0;
        // receiver holds off while the sender keeps offering behind the flush
        hold_reqs++;
        send_item(OP_FLUSH, random_record(), 1'b1);
        repeat (6) send_item(OP_ADD, random_record(), 1'b1);
        send_item(OP_FLUSH, random_record(), 1'b1);

        // random rounds: pick a mode, a burst of adds, usually a flush
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            sel = $urandom_range(9);
            m   = (sel >= 1 && sel <= 4) || sel == 9;
            y   = (sel >= 5);
            set_modes(m, y);
            repeat ($urandom_range(1, 24)) begin
                if ($urandom_range(99) < 5) begin
                    send_item(OP_FLUSH, random_record(), 1'b1);
                    n_rand++;
                end else begin
                    send_item(OP_ADD, random_record(), 1'b1);
                    if (m || y) n_rand++;
                end
            end
            if ($urandom_range(99) < 80) begin
                send_item(OP_FLUSH, random_record(), 1'b1);
                n_rand++;
                if ($urandom_range(99) < 10) begin
                    send_item(OP_FLUSH, random_record(), 1'b1);
                    n_rand++;
                end
            end
        end

        // drain and report
        go_quiet();
        while (due_groups.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/kgsa_pkg.sv
rtl/keyed_group_sum_aggregator_core.sv
rtl/kgsa_checker.sv
dv/tb.sv
